@@ hdl/gcd_lcm_unit_top_macros.svh @@
// assertion macros for the gcd/lcm unit top level
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef GCD_LCM_UNIT_TOP_MACROS_SVH
`define GCD_LCM_UNIT_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define GLU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define GLU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/glu_pkg.sv @@
// shared constants and types of the gcd/lcm unit
// no dependencies
`default_nettype none

package glu_pkg;

  // operand width used by the datapath (8 to 32)
  localparam int unsigned OpW   = 32;
  // counter width for bit loops and the common power of two
  localparam int unsigned CntW  = $clog2(OpW);
  // product width and result port width
  localparam int unsigned ProdW = 2 * OpW;
  localparam int unsigned ResW  = 64;

  // finished result handed from the sequencer to the output stage
  typedef struct packed {
    logic            valid;
    logic [ResW-1:0] value;
  } glu_res_t;

endpackage

`default_nettype wire

@@ hdl/glu_alu.sv @@
// shared add/subtract unit of the gcd/lcm unit
// depends on glu_pkg
`default_nettype none

module glu_alu import glu_pkg::*; (
  input  logic [OpW:0] op_a_i,
  input  logic [OpW:0] op_b_i,
  input  logic         sub_i,
  output logic [OpW:0] sum_o,
  output logic         carry_o
);

  logic [OpW:0]   op_b_eff;
  logic [OpW+1:0] full_sum;

  // a + b, or a - b as a + ~b + 1; carry high means no borrow
  assign op_b_eff = sub_i ? ~op_b_i : op_b_i;
  assign full_sum = {1'b0, op_a_i} + {1'b0, op_b_eff} + {{(OpW+1){1'b0}}, sub_i};
  assign sum_o    = full_sum[OpW:0];
  assign carry_o  = full_sum[OpW+1];

endmodule

`default_nettype wire

@@ hdl/glu_seq.sv @@
// sequencer and datapath registers of the gcd/lcm unit: binary gcd,
// restoring divide of b by the gcd, shift-add multiply by a
// depends on glu_pkg and glu_alu
`default_nettype none

module glu_seq import glu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output glu_res_t    res_o,
  input  logic        res_ready_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_SHL,
    S_DIV,
    S_MUL,
    S_DONE
  } state_e;

  state_e           state_q, state_d;
  logic             kind_q, kind_d;
  logic [OpW-1:0]   a_q, a_d;
  logic [OpW-1:0]   b_q, b_d;
  logic [OpW-1:0]   x_q, x_d;
  logic [OpW-1:0]   y_q, y_d;
  logic [OpW-1:0]   rem_q, rem_d;
  logic [CntW-1:0]  k_q, k_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ProdW-1:0] prod_q, prod_d;

  logic [OpW-1:0]   a_m, b_m;
  logic [OpW:0]     alu_a, alu_b, alu_sum;
  logic             alu_sub, alu_carry;
  logic             cnt_last;

  // operands reduced to the datapath width
  assign a_m = operand_a_i[OpW-1:0];
  assign b_m = operand_b_i[OpW-1:0];

  assign cnt_last = (cnt_q == CntW'(OpW - 1));

  // operand select for the shared unit
  always_comb begin
    alu_a   = {1'b0, x_q};
    alu_b   = {1'b0, y_q};
    alu_sub = 1'b1;
    case (state_q)
      S_DIV: begin
        alu_a = {rem_q, y_q[OpW-1]};
        alu_b = {1'b0, x_q};
      end
      S_MUL: begin
        alu_a   = {1'b0, prod_q[ProdW-1:OpW]};
        alu_b   = {1'b0, a_q};
        alu_sub = 1'b0;
      end
      default: begin
        alu_a   = {1'b0, x_q};
        alu_b   = {1'b0, y_q};
        alu_sub = 1'b1;
      end
    endcase
  end

  glu_alu u_alu (
    .op_a_i  (alu_a),
    .op_b_i  (alu_b),
    .sub_i   (alu_sub),
    .sum_o   (alu_sum),
    .carry_o (alu_carry)
  );

  // next-state and datapath update
  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    a_d     = a_q;
    b_d     = b_q;
    x_d     = x_q;
    y_d     = y_q;
    rem_d   = rem_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d = kind_i;
          a_d    = a_m;
          b_d    = b_m;
          x_d    = a_m;
          y_d    = b_m;
          k_d    = '0;
          if (a_m == '0 || b_m == '0) begin
            // zero operand: gcd reads as one, lcm as zero
            prod_d  = kind_i ? '0 : ProdW'(1);
            state_d = S_DONE;
          end else begin
            state_d = S_GCD;
          end
        end
      end
      S_GCD: begin
        if (!x_q[0] && !y_q[0]) begin
          // common factor of two
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (alu_carry && alu_sum[OpW-1:0] == '0) begin
          // equal odd values: odd part of the gcd found
          state_d = S_SHL;
        end else if (alu_carry) begin
          x_d = alu_sum[OpW-1:0];
        end else begin
          // keep the larger value in x
          x_d = y_q;
          y_d = x_q;
        end
      end
      S_SHL: begin
        if (k_q == '0) begin
          if (!kind_q) begin
            prod_d  = {{OpW{1'b0}}, x_q};
            state_d = S_DONE;
          end else begin
            y_d     = b_q;
            rem_d   = '0;
            cnt_d   = '0;
            state_d = S_DIV;
          end
        end else begin
          x_d = x_q << 1;
          k_d = k_q - 1'b1;
        end
      end
      S_DIV: begin
        // one quotient bit of b / gcd per cycle
        if (alu_carry) begin
          rem_d = alu_sum[OpW-1:0];
        end else begin
          rem_d = {rem_q[OpW-2:0], y_q[OpW-1]};
        end
        y_d   = {y_q[OpW-2:0], alu_carry};
        cnt_d = cnt_q + 1'b1;
        if (cnt_last) begin
          prod_d  = {{OpW{1'b0}}, y_q[OpW-2:0], alu_carry};
          cnt_d   = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        // one multiplier bit of a * quotient per cycle
        if (prod_q[0]) begin
          prod_d = {alu_sum, prod_q[OpW-1:1]};
        end else begin
          prod_d = prod_q >> 1;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_last) begin
          cnt_d   = '0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    a_q    <= a_d;
    b_q    <= b_d;
    x_q    <= x_d;
    y_q    <= y_d;
    rem_q  <= rem_d;
    k_q    <= k_d;
    cnt_q  <= cnt_d;
    prod_q <= prod_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_o.valid = (state_q == S_DONE);
  assign res_o.value = ResW'(prod_q);

endmodule

`default_nettype wire

@@ hdl/gcd_lcm_unit_top.sv @@
// gcd/lcm unit top level: sequencer plus output register; uses glu_pkg, glu_seq
// a zero operand goes straight to the result; gcd runs the binary gcd loop on
// the shared add/subtract unit; lcm goes on to a bit-serial divide and multiply
// on the same unit
// throughput: one beat at a time; the next beat is taken once the result is registered
// reset: asynchronous active low, clears the sequencer and output valid
`default_nettype none

`include "gcd_lcm_unit_top_macros.svh"

module gcd_lcm_unit_top import glu_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            kind_i,
  input  logic [31:0]     operand_a_i,
  input  logic [31:0]     operand_b_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [ResW-1:0] result_o
);

  glu_res_t        res;
  logic            res_ready;
  logic            out_valid_q, out_valid_d;
  logic [ResW-1:0] result_q;

  glu_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // output register frees the sequencer while the beat waits
  assign res_ready   = !out_valid_q || out_ready_i;
  assign out_valid_d = res.valid || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      result_q <= res.value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  // checks
  `GLU_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o,
                   "sequencer ready right after taking a beat")
  `GLU_ASSERT_NOW(a_no_accept_when_done, res.valid, !in_ready_o,
                  "sequencer ready while holding a result")
  `GLU_ASSERT_NEXT(a_result_lands, res.valid && res_ready, out_valid_o,
                   "handed-off result missing from output register")

endmodule

`default_nettype wire
